/* rtl/abme_pkg.sv */
// Shared types and constants for the AXI burst beat engine.
// Depends on nothing; imported by the channel interfaces and the core.
package abme_pkg;

  localparam int unsigned MemBytesDefault = 65536;
  localparam int unsigned DataBytes       = 8;
  localparam int unsigned LaneMax         = (DataBytes < 8) ? DataBytes : 8;
  localparam logic [16:0] UsedMax         = 17'h1FFFF;
  localparam logic [8:0]  BeatMax         = 9'd511;

  typedef enum logic {
    REQ_READ,
    REQ_WRITE
  } req_e;

  typedef enum logic [1:0] {
    BT_FIXED,
    BT_INCR,
    BT_WRAP,
    BT_RSVD
  } burst_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BURST_ERR,
    ST_ADDR_ERR,
    ST_SKIP
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL,
    S_DIVIDE,
    S_WRAP_OFF,
    S_WRAP_SUM,
    S_CHECK,
    S_MOVE,
    S_DRAIN,
    S_FINISH
  } fsm_e;

  typedef struct packed {
    req_e         req_type;
    logic         first_beat;
    logic [31:0]  burst_addr;
    logic [7:0]   burst_len;
    logic [1:0]   beat_size;
    burst_e       burst_type;
    logic [11:0]  xfer_bytes;
    logic [63:0]  write_data;
  } beat_req_t;

  typedef struct packed {
    logic [63:0]  read_data;
    logic [31:0]  beat_address;
    status_e      status;
    logic [3:0]   bytes_moved;
    logic         last_beat;
    logic [16:0]  used_bytes;
  } beat_rsp_t;

endpackage

/* rtl/abme_if.sv */
// Valid/ready channels for beat requests and beat responses.
// Depends on abme_pkg for the payload structs.
interface abme_req_if import abme_pkg::*; ();
  logic      valid;
  logic      ready;
  beat_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface abme_rsp_if import abme_pkg::*; ();
  logic      valid;
  logic      ready;
  beat_rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/axi_burst_memory_beat_engine_core.sv */
// AXI burst beat engine: address generation, byte memory and written marks.
// Depends on abme_pkg and the channel interfaces in abme_if.sv.
//
// Usage: one request word per burst beat enters on req_i; one response word
// per beat leaves on rsp_o. first_beat restarts the beat counter of a burst.
// Memory entries hold a byte and its written mark; a beat reads each byte
// once and, for writes, stores the write data byte with the mark set.
// After accept a beat runs S_EVAL, then the states below, then S_FINISH:
//   skipped or bad burst type      no further states
//   address error / no data left   S_CHECK
//   moving N bytes                 S_CHECK, S_MOVE per byte, S_DRAIN
// Wrapping bursts run S_DIVIDE, a bit-serial remainder unit for the wrap
// window, then S_WRAP_OFF and S_WRAP_SUM, before S_CHECK. Byte traffic is one
// memory access per cycle; a beat is worked on alone and the next word is
// accepted once the previous response is registered, which needs a free output.
// After reset the memory is swept to zero, one entry a cycle, with req_i not
// ready. A stalled response holds in the output register; one more beat may
// be accepted and worked on behind it, waiting in S_FINISH until it is free.
module axi_burst_memory_beat_engine_core import abme_pkg::*; #(
  parameter int unsigned MEM_BYTES = MemBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  abme_req_if.sink    req_i,
  abme_rsp_if.source  rsp_o
);

  localparam int unsigned AW       = $clog2(MEM_BYTES);
  localparam logic [32:0] MemLimit = 33'(MEM_BYTES);
  localparam logic [3:0]  LaneCnt  = 4'(LaneMax);

  fsm_e            state_q, state_d;
  beat_req_t       req_q;
  logic [8:0]      beat_idx_q;
  logic            ended_q;
  logic [16:0]     used_q;
  logic [AW-1:0]   clr_addr_q;
  logic [4:0]      div_cnt_q;
  logic [11:0]     rem_q;
  logic [11:0]     rem2_q;
  logic [31:0]     addr_q;
  logic [11:0]     off_q;
  logic [3:0]      cnt_q;
  logic [2:0]      idx_q;
  logic            last_q;
  status_e         status_q;
  logic            p_valid_q;
  logic [2:0]      p_idx_q;
  logic [AW-1:0]   p_addr_q;
  logic [8:0]      rd_q;
  logic [63:0]     rdata_q;
  logic [3:0]      moved_q;
  logic            out_valid_q;
  beat_rsp_t       out_q;

  logic [8:0]      mem_q [MEM_BYTES];

  logic [8:0]      beats;
  logic [3:0]      bbytes;
  logic [11:0]     total;
  logic [11:0]     step;
  logic            skip;
  logic [11:0]     div_t;
  logic [11:0]     div_r;
  logic [31:0]     wdvd;
  logic [11:0]     div2_t;
  logic [11:0]     div2_r;
  logic [11:0]     left;
  logic [3:0]      cnt_a;
  logic [3:0]      cnt_c;
  logic            addr_oob;
  logic [32:0]     byte_addr;
  logic            byte_ok;
  logic            accept;
  logic            out_free;
  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  logic [8:0]      mem_wd;
  logic            wr_beat;

  assign beats     = {1'b0, req_q.burst_len} + 9'd1;
  assign bbytes    = 4'd1 << req_q.beat_size;
  assign total     = 12'(beats) << req_q.beat_size;
  assign step      = 12'(beat_idx_q[7:0]) << req_q.beat_size;
  assign skip      = ended_q || (beat_idx_q >= beats);
  assign div_t     = {rem_q[10:0], req_q.burst_addr[div_cnt_q]};
  assign div_r     = (div_t >= total) ? div_t - total : div_t;
  assign wdvd      = req_q.burst_addr + 32'(step);
  assign div2_t    = {rem2_q[10:0], wdvd[div_cnt_q]};
  assign div2_r    = (div2_t >= total) ? div2_t - total : div2_t;
  assign left      = (req_q.xfer_bytes > step) ? req_q.xfer_bytes - step : 12'd0;
  assign cnt_a     = (12'(bbytes) < left) ? bbytes : left[3:0];
  assign cnt_c     = (cnt_a > LaneCnt) ? LaneCnt : cnt_a;
  assign addr_oob  = {1'b0, addr_q} >= MemLimit;
  assign byte_addr = 33'(addr_q) + 33'(idx_q);
  assign byte_ok   = byte_addr < MemLimit;
  assign accept    = req_i.valid && req_i.ready;
  assign out_free  = !out_valid_q || rsp_o.ready;
  assign wr_beat   = (req_q.req_type == REQ_WRITE);

  assign mem_we = (state_q == S_CLEAR) || (p_valid_q && wr_beat);
  assign mem_wa = (state_q == S_CLEAR) ? clr_addr_q : p_addr_q;
  assign mem_wd = (state_q == S_CLEAR) ? 9'd0
                : {1'b1, req_q.write_data[{p_idx_q, 3'b000} +: 8]};

  assign req_i.ready   = (state_q == S_IDLE);
  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_addr_q == AW'(MEM_BYTES - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (req_i.valid) state_d = S_EVAL;
      end
      S_EVAL: begin
        if (skip || req_q.burst_type == BT_RSVD) state_d = S_FINISH;
        else if (req_q.burst_type == BT_WRAP)    state_d = S_DIVIDE;
        else                                     state_d = S_CHECK;
      end
      S_DIVIDE: begin
        if (div_cnt_q == 5'd0) state_d = S_WRAP_OFF;
      end
      S_WRAP_OFF: state_d = S_WRAP_SUM;
      S_WRAP_SUM: state_d = S_CHECK;
      S_CHECK: begin
        if (addr_oob || cnt_c == 4'd0) state_d = S_FINISH;
        else                           state_d = S_MOVE;
      end
      S_MOVE: begin
        if ({1'b0, idx_q} == cnt_q - 4'd1) state_d = S_DRAIN;
      end
      S_DRAIN: state_d = S_FINISH;
      S_FINISH: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_addr_q  <= '0;
      beat_idx_q  <= '0;
      ended_q     <= 1'b0;
      used_q      <= '0;
      p_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      p_valid_q <= (state_q == S_MOVE) && byte_ok;
      if (state_q == S_CLEAR) clr_addr_q <= clr_addr_q + AW'(1);
      if (accept && req_i.payload.first_beat) begin
        beat_idx_q <= '0;
        ended_q    <= 1'b0;
      end
      if (p_valid_q && wr_beat && !rd_q[8] && used_q != UsedMax) begin
        used_q <= used_q + 17'd1;
      end
      if (state_q == S_FINISH && out_free) begin
        out_valid_q <= 1'b1;
        ended_q     <= ended_q | last_q;
        if (beat_idx_q != BeatMax) beat_idx_q <= beat_idx_q + 9'd1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) req_q <= req_i.payload;
    unique case (state_q)
      S_EVAL: begin
        rdata_q   <= '0;
        moved_q   <= '0;
        rem_q     <= '0;
        rem2_q    <= '0;
        div_cnt_q <= 5'd31;
        if (skip) begin
          status_q <= ST_SKIP;
          last_q   <= 1'b0;
          addr_q   <= '0;
        end else if (req_q.burst_type == BT_RSVD) begin
          status_q <= ST_BURST_ERR;
          last_q   <= 1'b1;
          addr_q   <= '0;
        end else begin
          status_q <= ST_OK;
          last_q   <= 1'b0;
          addr_q   <= (req_q.burst_type == BT_FIXED) ? req_q.burst_addr
                    : req_q.burst_addr + 32'(step);
        end
      end
      S_DIVIDE: begin
        rem_q     <= div_r;
        rem2_q    <= div2_r;
        div_cnt_q <= div_cnt_q - 5'd1;
      end
      S_WRAP_OFF: begin
        off_q  <= rem2_q;
        addr_q <= req_q.burst_addr - 32'(rem_q);
      end
      S_WRAP_SUM: addr_q <= addr_q + 32'(off_q);
      S_CHECK: begin
        if (addr_oob) begin
          status_q <= ST_ADDR_ERR;
          last_q   <= 1'b1;
        end else if (cnt_c == 4'd0) begin
          last_q <= 1'b1;
        end else begin
          cnt_q  <= cnt_c;
          idx_q  <= '0;
          last_q <= (beat_idx_q == {1'b0, req_q.burst_len});
        end
      end
      S_MOVE: begin
        idx_q    <= idx_q + 3'd1;
        p_idx_q  <= idx_q;
        p_addr_q <= byte_addr[AW-1:0];
      end
      S_FINISH: begin
        if (out_free) begin
          out_q.read_data    <= rdata_q;
          out_q.beat_address <= addr_q;
          out_q.status       <= status_q;
          out_q.bytes_moved  <= moved_q;
          out_q.last_beat    <= last_q;
          out_q.used_bytes   <= used_q;
        end
      end
      default: ;
    endcase
    if (p_valid_q) begin
      moved_q <= moved_q + 4'd1;
      if (!wr_beat) rdata_q[{p_idx_q, 3'b000} +: 8] <= rd_q[7:0];
    end
  end

  // byte memory: {written mark, data}
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    if (state_q == S_MOVE) rd_q <= mem_q[byte_addr[AW-1:0]];
  end

endmodule
